// File: rtl/rza_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rza_pkg;

    localparam int REG_INDEX_BITS = 3;
    localparam int REG_BITS       = 16;
    localparam int ACC_BITS       = 32;
    localparam int FRAC_BITS      = 16;
    localparam int ORIGIN_SHIFT   = 4;
    localparam int STEP_SHIFT     = 8;
    localparam int FIXED_X_OFFSET = 38;

    localparam logic [REG_INDEX_BITS-1:0] REG_STEP_X_COL = 3'd0;
    localparam logic [REG_INDEX_BITS-1:0] REG_STEP_Y_COL = 3'd1;
    localparam logic [REG_INDEX_BITS-1:0] REG_STEP_X_ROW = 3'd2;
    localparam logic [REG_INDEX_BITS-1:0] REG_STEP_Y_ROW = 3'd3;
    localparam logic [REG_INDEX_BITS-1:0] REG_ORIGIN_X   = 3'd4;
    localparam logic [REG_INDEX_BITS-1:0] REG_ORIGIN_Y   = 3'd5;
    localparam logic [REG_INDEX_BITS-1:0] REG_MODE       = 3'd6;

    localparam logic [REG_BITS-1:0] MODE_RESET       = 16'h4400;
    localparam logic [REG_BITS-1:0] MODE_CLAMP_LARGE = 16'h4488;
    localparam logic [REG_BITS-1:0] MODE_CLAMP_ALT   = 16'h44cc;
    localparam logic [REG_BITS-1:0] MODE_CLAMP_SMALL = 16'h44ee;

    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef struct packed {
        logic                valid;
        logic [ACC_BITS-1:0] acc_x;
        logic [ACC_BITS-1:0] acc_y;
    } seed_t;

endpackage

`default_nettype wire

// File: rtl/rza_seed.sv
`timescale 1ns / 1ps
`default_nettype none

module rza_seed #(
    parameter int SCREEN_COORD_BITS = 10
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [SCREEN_COORD_BITS-1:0]  clip_left,
    input  wire logic [SCREEN_COORD_BITS-1:0]  clip_top,
    input  wire logic [rza_pkg::REG_BITS-1:0]  step_x_col,
    input  wire logic [rza_pkg::REG_BITS-1:0]  step_y_col,
    input  wire logic [rza_pkg::REG_BITS-1:0]  step_x_row,
    input  wire logic [rza_pkg::REG_BITS-1:0]  step_y_row,
    input  wire logic [rza_pkg::REG_BITS-1:0]  origin_x,
    input  wire logic [rza_pkg::REG_BITS-1:0]  origin_y,
    output rza_pkg::seed_t                     seed
);

    localparam int AW = rza_pkg::ACC_BITS;

    logic          valid_reg;
    logic [AW-1:0] base_x_reg, left_x_reg, top_x_reg;
    logic [AW-1:0] base_y_reg, left_y_reg, top_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= start;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            base_x_reg <= AW'($signed(origin_x) * (2 ** rza_pkg::ORIGIN_SHIFT))
                        + AW'($signed(step_x_col) * rza_pkg::FIXED_X_OFFSET);
            base_y_reg <= AW'($signed(origin_y) * (2 ** rza_pkg::ORIGIN_SHIFT))
                        + AW'($signed(step_y_col) * rza_pkg::FIXED_X_OFFSET);
            left_x_reg <= AW'($signed({1'b0, clip_left}) * $signed(step_x_col));
            left_y_reg <= AW'($signed({1'b0, clip_left}) * $signed(step_y_col));
            top_x_reg  <= AW'($signed({1'b0, clip_top}) * $signed(step_x_row));
            top_y_reg  <= AW'($signed({1'b0, clip_top}) * $signed(step_y_row));
        end
    end

    always_comb begin
        seed.valid = valid_reg;
        seed.acc_x = (base_x_reg + left_x_reg + top_x_reg) << rza_pkg::STEP_SHIFT;
        seed.acc_y = (base_y_reg + left_y_reg + top_y_reg) << rza_pkg::STEP_SHIFT;
    end

endmodule

`default_nettype wire

// File: rtl/rotate_zoom_address_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// A tick word in an active region yields its result word in the cycle after acceptance.
// Tick words are accepted every cycle while the output register is free or being drained.
// For a start word, the seed multiplies are registered, then summed into the
// accumulators, so s_tready is low in the cycle after a start. Start words give no result.
// Reset is synchronous on aresetn low: registers return to their reset values, region idle.

module rotate_zoom_address_generator #(
    parameter int SCREEN_COORD_BITS = 10,
    parameter int LARGE_MAP_SIZE    = 2048,
    parameter int SMALL_MAP_SIZE    = 256,
    localparam int S_DATA_W = ((4 * SCREEN_COORD_BITS + 7) / 8) * 8,
    localparam int M_DATA_W = ((2 * rza_pkg::FRAC_BITS + 1 + 2 * SCREEN_COORD_BITS + 7) / 8) * 8
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [rza_pkg::REG_INDEX_BITS-1:0]   cfg_addr,
    input  wire logic [rza_pkg::REG_BITS-1:0]         cfg_wdata,
    input  wire logic                                 s_tvalid,
    output      logic                                 s_tready,
    // clip_left, clip_right, clip_top, clip_bottom
    input  wire logic [S_DATA_W-1:0]                  s_tdata,
    // operation
    input  wire logic                                 s_tuser,
    output      logic                                 m_tvalid,
    input  wire logic                                 m_tready,
    // source_x, source_y, in_range, screen_x, screen_y
    output      logic [M_DATA_W-1:0]                  m_tdata,
    output      logic                                 m_tlast
);

    localparam int CW = SCREEN_COORD_BITS;
    localparam int AW = rza_pkg::ACC_BITS;
    localparam int RW = rza_pkg::REG_BITS;
    localparam int FW = rza_pkg::FRAC_BITS;
    localparam logic [FW-1:0] LARGE_MASK = FW'(LARGE_MAP_SIZE - 1);
    localparam logic [FW:0]   LARGE_SIZE = (FW + 1)'(LARGE_MAP_SIZE);
    localparam logic [FW:0]   SMALL_SIZE = (FW + 1)'(SMALL_MAP_SIZE);

    logic [RW-1:0] step_x_col_reg, step_y_col_reg, step_x_row_reg, step_y_row_reg;
    logic [RW-1:0] origin_x_reg, origin_y_reg, mode_reg;

    logic [AW-1:0] row_acc_x_reg, row_acc_y_reg, pix_acc_x_reg, pix_acc_y_reg;
    logic [CW-1:0] cur_col_reg, cur_row_reg;
    logic [CW-1:0] left_reg, right_reg, bottom_reg;
    logic          active_reg;

    logic          out_valid_reg, out_valid_next;
    logic [FW-1:0] out_sx_reg, out_sy_reg;
    logic          out_ok_reg, out_last_reg;
    logic [CW-1:0] out_col_reg, out_row_reg;

    logic [CW-1:0] in_left, in_right, in_top, in_bottom;
    logic          in_fire, start_fire, tick_fire, emit;
    logic          wrap, ok, is_last, row_end;
    logic [FW:0]   size;
    logic [FW-1:0] raw_sx, raw_sy, sx, sy;
    logic [AW-1:0] step_x_col_ext, step_y_col_ext, step_x_row_ext, step_y_row_ext;

    rza_pkg::seed_t seed;

    assign in_left   = s_tdata[CW-1:0];
    assign in_right  = s_tdata[2*CW-1:CW];
    assign in_top    = s_tdata[3*CW-1:2*CW];
    assign in_bottom = s_tdata[4*CW-1:3*CW];

    assign s_tready   = !seed.valid && (!out_valid_reg || m_tready);
    assign in_fire    = s_tvalid && s_tready;
    assign start_fire = in_fire && (s_tuser == rza_pkg::OP_START);
    assign tick_fire  = in_fire && (s_tuser == rza_pkg::OP_TICK);
    assign emit       = tick_fire && active_reg;

    rza_seed #(
        .SCREEN_COORD_BITS(SCREEN_COORD_BITS)
    ) u_seed (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (start_fire),
        .clip_left  (in_left),
        .clip_top   (in_top),
        .step_x_col (step_x_col_reg),
        .step_y_col (step_y_col_reg),
        .step_x_row (step_x_row_reg),
        .step_y_row (step_y_row_reg),
        .origin_x   (origin_x_reg),
        .origin_y   (origin_y_reg),
        .seed       (seed)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_x_col_reg <= '0;
            step_y_col_reg <= '0;
            step_x_row_reg <= '0;
            step_y_row_reg <= '0;
            origin_x_reg   <= '0;
            origin_y_reg   <= '0;
            mode_reg       <= rza_pkg::MODE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                rza_pkg::REG_STEP_X_COL: step_x_col_reg <= cfg_wdata;
                rza_pkg::REG_STEP_Y_COL: step_y_col_reg <= cfg_wdata;
                rza_pkg::REG_STEP_X_ROW: step_x_row_reg <= cfg_wdata;
                rza_pkg::REG_STEP_Y_ROW: step_y_row_reg <= cfg_wdata;
                rza_pkg::REG_ORIGIN_X:   origin_x_reg   <= cfg_wdata;
                rza_pkg::REG_ORIGIN_Y:   origin_y_reg   <= cfg_wdata;
                rza_pkg::REG_MODE:       mode_reg       <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign step_x_col_ext = AW'($signed(step_x_col_reg)) << rza_pkg::STEP_SHIFT;
    assign step_y_col_ext = AW'($signed(step_y_col_reg)) << rza_pkg::STEP_SHIFT;
    assign step_x_row_ext = AW'($signed(step_x_row_reg)) << rza_pkg::STEP_SHIFT;
    assign step_y_row_ext = AW'($signed(step_y_row_reg)) << rza_pkg::STEP_SHIFT;

    always_comb begin
        wrap = 1'b1;
        size = LARGE_SIZE;
        case (mode_reg)
            rza_pkg::MODE_CLAMP_LARGE, rza_pkg::MODE_CLAMP_ALT: begin
                wrap = 1'b0;
            end
            rza_pkg::MODE_CLAMP_SMALL: begin
                wrap = 1'b0;
                size = SMALL_SIZE;
            end
            default: begin
            end
        endcase
        raw_sx = pix_acc_x_reg[AW-1:AW-FW];
        raw_sy = pix_acc_y_reg[AW-1:AW-FW];
        if (wrap) begin
            sx = raw_sx & LARGE_MASK;
            sy = raw_sy & LARGE_MASK;
            ok = 1'b1;
        end else begin
            sx = raw_sx;
            sy = raw_sy;
            ok = ({1'b0, raw_sx} < size) && ({1'b0, raw_sy} < size);
        end
        row_end = (cur_col_reg == right_reg);
        is_last = row_end && (cur_row_reg == bottom_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            row_acc_x_reg <= '0;
            row_acc_y_reg <= '0;
            pix_acc_x_reg <= '0;
            pix_acc_y_reg <= '0;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            left_reg      <= '0;
            right_reg     <= '0;
            bottom_reg    <= '0;
        end else if (seed.valid) begin
            row_acc_x_reg <= seed.acc_x;
            row_acc_y_reg <= seed.acc_y;
            pix_acc_x_reg <= seed.acc_x;
            pix_acc_y_reg <= seed.acc_y;
        end else if (start_fire) begin
            cur_col_reg <= in_left;
            cur_row_reg <= in_top;
            left_reg    <= in_left;
            right_reg   <= in_right;
            bottom_reg  <= in_bottom;
            active_reg  <= (in_left <= in_right) && (in_top <= in_bottom);
        end else if (emit) begin
            if (row_end) begin
                if (is_last) begin
                    active_reg    <= 1'b0;
                    pix_acc_x_reg <= row_acc_x_reg;
                    pix_acc_y_reg <= row_acc_y_reg;
                end else begin
                    row_acc_x_reg <= row_acc_x_reg + step_x_row_ext;
                    row_acc_y_reg <= row_acc_y_reg + step_y_row_ext;
                    pix_acc_x_reg <= row_acc_x_reg + step_x_row_ext;
                    pix_acc_y_reg <= row_acc_y_reg + step_y_row_ext;
                    cur_row_reg   <= cur_row_reg + CW'(1);
                end
                cur_col_reg <= left_reg;
            end else begin
                pix_acc_x_reg <= pix_acc_x_reg + step_x_col_ext;
                pix_acc_y_reg <= pix_acc_y_reg + step_y_col_ext;
                cur_col_reg   <= cur_col_reg + CW'(1);
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_sx_reg   <= sx;
            out_sy_reg   <= sy;
            out_ok_reg   <= ok;
            out_col_reg  <= cur_col_reg;
            out_row_reg  <= cur_row_reg;
            out_last_reg <= is_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'({out_row_reg, out_col_reg, out_ok_reg, out_sy_reg, out_sx_reg});
    assign m_tlast  = out_last_reg;

    a_no_accept_while_seeding: assert property (
        @(posedge aclk) disable iff (!aresetn) seed.valid |-> !s_tready
    ) else $error("input accepted while accumulators are being seeded");

    a_seed_follows_start: assert property (
        @(posedge aclk) disable iff (!aresetn) start_fire |=> seed.valid
    ) else $error("start word did not seed the accumulators");

    a_last_ends_region: assert property (
        @(posedge aclk) disable iff (!aresetn) (emit && is_last) |=> !active_reg
    ) else $error("region still active after its last pixel");

    a_position_in_bounds: assert property (
        @(posedge aclk) disable iff (!aresetn)
        active_reg |-> (cur_col_reg <= right_reg) && (cur_row_reg <= bottom_reg)
    ) else $error("pixel position outside the region bounds");

endmodule

`default_nettype wire
